// ===== rtl/isort_pkg.sv =====
// shared types for the insertion sorter: value width, controller states,
// and the command and status bundles between controller and datapath
// no dependencies
package isort_pkg;

   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic insert;   // place the incoming value into the cell row
      logic pop;      // shift the row toward the head by one cell
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;     // every cell holds a value
      logic last;     // exactly one value is left
   } status_type;

endpackage

// ===== rtl/isort_req_if.sv =====
// input channel of the insertion sorter: one value per beat
// depends on isort_pkg
interface isort_req_if
   import isort_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      batch_end;

   modport source (output valid, output value, output batch_end, input ready);
   modport sink   (input valid, input value, input batch_end, output ready);
endinterface

// ===== rtl/isort_rsp_if.sv =====
// result channel of the insertion sorter: one sorted value per beat
// depends on isort_pkg
interface isort_rsp_if
   import isort_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] sorted_value;
   logic                      final_res;
   logic                      dropped;

   modport source (output valid, output sorted_value, output final_res,
                   output dropped, input ready);
   modport sink   (input valid, input sorted_value, input final_res,
                   input dropped, output ready);
endinterface

// ===== rtl/isort_datapath.sv =====
// row of compare-and-shift cells holding the sorted batch, plus fill count
// depends on isort_pkg
module isort_datapath
   import isort_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   input  logic signed [VALUE_W-1:0] in_value,
   output status_type                status,
   output logic signed [VALUE_W-1:0] head_value
);

   localparam int CW = $clog2(DEPTH + 1);

   logic signed [VALUE_W-1:0] cell_ff [DEPTH];
   logic signed [VALUE_W-1:0] cell_in [DEPTH];
   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic [DEPTH-1:0]          greater;

   // each occupied cell compares against the new value in parallel
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         greater[i] = (CW'(i) < count_ff) && (cell_ff[i] > in_value);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_in[i] = cell_ff[i];
         if (cmd.insert) begin
            // cells above the insertion point move up one place
            if (i > 0 && greater[(i > 0) ? i - 1 : 0]) begin
               cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
            end else if (greater[i] || CW'(i) == count_ff) begin
               cell_in[i] = in_value;
            end
         end else if (cmd.pop) begin
            if (i < DEPTH - 1) begin
               cell_in[i] = cell_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   assign status.full = (count_ff == CW'(DEPTH));
   assign status.last = (count_ff == CW'(1));
   assign head_value  = cell_ff[0];

endmodule

// ===== rtl/isort_ctrl.sv =====
// controller of the insertion sorter: load and drain phases, sticky drop flag
// depends on isort_pkg
module isort_ctrl
   import isort_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_batch_end,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       dropped,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      overflow_ff, overflow_in;
   logic      req_beat, rsp_beat;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_DRAIN);
   assign req_beat  = req_valid && req_ready;
   assign rsp_beat  = rsp_valid && rsp_ready;

   assign cmd.insert = req_beat && !status.full;
   assign cmd.pop    = rsp_beat;

   always_comb begin
      state_in    = state_ff;
      overflow_in = overflow_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_beat) begin
               if (status.full) begin
                  overflow_in = 1'b1;
               end
               if (req_batch_end) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_beat && status.last) begin
               state_in    = ST_LOAD;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in    = ST_LOAD;
            overflow_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
      end
   end

   assign dropped = overflow_ff;

endmodule

// ===== rtl/insertion_sorter_core.sv =====
// Stable insertion sorter for batches of signed 32-bit values. While loading,
// one value is accepted every cycle: a row of DEPTH cells compares all held
// values with the new one and shifts the greater ones up in that same cycle,
// so equal values keep their arrival order. The beat with batch_end set is
// inserted too and ends loading; the batch of N values (1 to DEPTH) then
// drains from the head of the row, one result per cycle while rsp ready is
// high, with final_res on the last one. No input is taken during the drain,
// so the next batch is accepted only once the last result has gone out.
// Values arriving when the row is full are discarded and dropped is set on
// every result of that batch.
module insertion_sorter_core
   import isort_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   isort_req_if.sink          req_chan,
   isort_rsp_if.source        rsp_chan
);

   cmd_type    cmd;
   status_type status;
   logic       dropped;

   isort_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_batch_end (req_chan.batch_end),
      .req_ready     (req_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .dropped       (dropped),
      .status        (status),
      .cmd           (cmd)
   );

   isort_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .in_value   (req_chan.value),
      .status     (status),
      .head_value (rsp_chan.sorted_value)
   );

   assign rsp_chan.final_res = status.last;
   assign rsp_chan.dropped   = dropped;

   // loading and draining never overlap
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.insert && cmd.pop))
      else $error("insert and pop in the same cycle");

   // a value taken on a full row marks the batch as lossy
   a_drop_flag: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && status.full) |=> rsp_chan.dropped)
      else $error("drop not recorded");

   // the closing beat starts the drain
   a_drain_start: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.batch_end) |=> rsp_chan.valid)
      else $error("batch end did not start the drain");

   // after the last result the core is empty and clean
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.final_res)
         |=> (req_chan.ready && !rsp_chan.dropped && !rsp_chan.valid))
      else $error("core not cleared after the last result");

endmodule

// ===== bench/insertion_sorter_core_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for insertion_sorter_core: batches of signed values go in,
// each batch is predicted in a local sorted store and compared as it drains out
// depends on isort_pkg, isort_req_if, isort_rsp_if and the core
module insertion_sorter_core_test;
   import isort_pkg::*;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      batch_end;
      bit                        hold;      // wait for the previous batch to drain first
   } load_beat_type;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      final_res;
      logic                      dropped;
   } sorted_beat_type;

   logic clock;
   logic reset;

   isort_req_if req_chan ();
   isort_rsp_if rsp_chan ();

   insertion_sorter_core #(.DEPTH(DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   load_beat_type   pending_beats[$];
   sorted_beat_type expected_sorted[$];

   // local copy of the sorted store
   logic signed [VALUE_W-1:0] held_values[DEPTH];
   int unsigned               held_count;
   logic                      lost_flag;

   int send_idle_pct;
   int recv_stall_pct;
   int fail_count;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // insert one accepted value; on the batch end emit the whole sorted batch
   task automatic sort_insert(input logic signed [VALUE_W-1:0] v, input logic last);
      int unsigned     pos;
      sorted_beat_type res;
      if (held_count >= DEPTH) begin
         lost_flag = 1'b1;
      end else begin
         pos = held_count;
         while (pos > 0 && held_values[pos-1] > v) pos--;
         for (int unsigned k = held_count; k > pos; k--) held_values[k] = held_values[k-1];
         held_values[pos] = v;
         held_count++;
      end
      if (last) begin
         for (int unsigned k = 0; k < held_count; k++) begin
            res.value     = held_values[k];
            res.final_res = (k + 1 == held_count);
            res.dropped   = lost_flag;
            expected_sorted.insert(expected_sorted.size(), res);
         end
         held_count = 0;
         lost_flag  = 1'b0;
      end
   endtask

   function automatic bit send_now();
      if (pending_beats[0].hold && expected_sorted.size() != 0) return 1'b0;
      return $urandom_range(99) >= send_idle_pct;
   endfunction

   always @(posedge clock) begin : driver
      load_beat_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            sort_insert(req_chan.value, req_chan.batch_end);
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_beats.size() != 0 && send_now()) begin
               nxt = pending_beats.pop_front();
               req_chan.valid     <= 1'b1;
               req_chan.value     <= nxt.value;
               req_chan.batch_end <= nxt.batch_end;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      sorted_beat_type exp_beat;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_sorted.size() == 0) begin
               $error("unexpected result beat: sorted_value %0d", rsp_chan.sorted_value);
               fail_count++;
            end else begin
               exp_beat = expected_sorted.pop_front();
               if (rsp_chan.sorted_value !== exp_beat.value) begin
                  $error("sorted_value: expected %0d, got %0d",
                         exp_beat.value, rsp_chan.sorted_value);
                  fail_count++;
               end
               if (rsp_chan.final_res !== exp_beat.final_res) begin
                  $error("final_res: expected %0b, got %0b",
                         exp_beat.final_res, rsp_chan.final_res);
                  fail_count++;
               end
               if (rsp_chan.dropped !== exp_beat.dropped) begin
                  $error("dropped: expected %0b, got %0b",
                         exp_beat.dropped, rsp_chan.dropped);
                  fail_count++;
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL insertion_sorter_core");
         $finish;
      end
   end

   function automatic void push_beat(input logic signed [VALUE_W-1:0] v, input logic last,
                                     input bit hold);
      load_beat_type b;
      b.value     = v;
      b.batch_end = last;
      b.hold      = hold;
      pending_beats.insert(pending_beats.size(), b);
   endfunction

   // mix of wide random values, small ones that collide, and the extremes
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         5, 6:    return $signed($urandom_range(6)) - 3;
         7:       return $urandom_range(1) ? VAL_MAX : VAL_MIN;
         8:       return $urandom_range(1) ? VAL_MAX - $urandom_range(3)
                                           : VAL_MIN + $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   // returns the number of beats queued
   function automatic int queue_batch(input bit hold);
      int len;
      case ($urandom_range(19))
         15, 16:  len = DEPTH;
         17, 18:  len = DEPTH + $urandom_range(1, 4);
         19:      len = $urandom_range(7, DEPTH - 1);
         default: len = $urandom_range(1, 6);
      endcase
      for (int i = 0; i < len; i++)
         push_beat(pick_value(), i == len - 1, hold && i == 0);
      return len;
   endfunction

   initial begin : stimulus
      int queued;
      int target;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.value     = '0;
      req_chan.batch_end = 1'b0;
      rsp_chan.ready     = 1'b0;
      held_count         = 0;
      lost_flag          = 1'b0;
      fail_count         = 0;
      cycle_count        = 0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // single value at the bottom of the range
      push_beat(VAL_MIN, 1'b1, 1'b0);
      // extremes, zero, minus one, one and a repeated zero
      push_beat(VAL_MAX, 1'b0, 1'b0);
      push_beat(VAL_MIN, 1'b0, 1'b0);
      push_beat(0, 1'b0, 1'b0);
      push_beat(-1, 1'b0, 1'b0);
      push_beat(1, 1'b0, 1'b0);
      push_beat(0, 1'b1, 1'b0);
      // fill the store, then lose the batch end beat itself
      for (int i = 0; i < DEPTH; i++)
         push_beat((i * 32'h1234_5679) ^ 32'hA5A5_A5A5, 1'b0, 1'b0);
      push_beat(VAL_MAX, 1'b1, 1'b0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  target = 14; end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  target = 18; end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; target = 18; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; target = 18; end
         endcase
         queued = 0;
         while (queued < target)
            queued += queue_batch(queued == 0 || $urandom_range(7) == 0);
         while (pending_beats.size() != 0 || req_chan.valid || expected_sorted.size() != 0)
            @(negedge clock);
      end

      repeat (2 * DEPTH + 4) @(negedge clock);
      if (fail_count == 0)
         $display("PASS insertion_sorter_core");
      else
         $display("FAIL insertion_sorter_core");
      $finish;
   end

endmodule
